/* rtl/core/stsp_pkg.sv */
`default_nettype none

package stsp_pkg;

  // file constants, little-endian words
  localparam logic [31:0] MagicWord = 32'h4353_4620;
  localparam logic [31:0] LabelTag  = 32'h4C42_4C20;
  localparam logic [31:0] WrtsTag   = 32'h5354_5257;

  // result kinds
  localparam logic [3:0] KindVersion   = 4'd0;
  localparam logic [3:0] KindLabelCnt  = 4'd1;
  localparam logic [3:0] KindLanguage  = 4'd2;
  localparam logic [3:0] KindLabelHdr  = 4'd3;
  localparam logic [3:0] KindLabelChar = 4'd4;
  localparam logic [3:0] KindPairHdr   = 4'd5;
  localparam logic [3:0] KindValueByte = 4'd6;
  localparam logic [3:0] KindExtraHdr  = 4'd7;
  localparam logic [3:0] KindExtraByte = 4'd8;
  localparam logic [3:0] KindError     = 4'd9;

  // error codes
  localparam logic [31:0] ErrMagic     = 32'd0;
  localparam logic [31:0] ErrTag       = 32'd1;
  localparam logic [31:0] ErrLength    = 32'd2;
  localparam logic [31:0] ErrTruncated = 32'd3;

  typedef enum logic [15:0] {
    PH_MAGIC   = 16'h0001,
    PH_VERSION = 16'h0002,
    PH_COUNT   = 16'h0004,
    PH_SKIP1   = 16'h0008,
    PH_SKIP2   = 16'h0010,
    PH_LANG    = 16'h0020,
    PH_LTAG    = 16'h0040,
    PH_NPAIRS  = 16'h0080,
    PH_NAMELEN = 16'h0100,
    PH_NAME    = 16'h0200,
    PH_PTAG    = 16'h0400,
    PH_VALLEN  = 16'h0800,
    PH_VALUE   = 16'h1000,
    PH_EXLEN   = 16'h2000,
    PH_EXTRA   = 16'h4000,
    PH_DONE    = 16'h8000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] word;
    logic [30:0] str_length;
    logic        has_extra;
    logic        ends_string;
    logic        ends_pair;
    logic        ends_label;
    logic        ends_file;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/string_table_stream_parser.sv */
`default_nettype none

// channel   direction  handshake                     payload
// input     in         in_valid_i / in_stall_o       stsp_pkg::in_item_t  (one file byte)
// output    out        out_valid_o / out_stall_i     stsp_pkg::out_item_t (zero or one per byte)
//
// one byte per cycle while no result stalls; path: input register, parse step, result register
// the rate is set by the single parse step between the input register and the result register
// rst_ni clears the parser to wait for the magic word, all counters to zero
// a stalled result holds the pipeline: the result register and a filled input register stop together
// a file_last byte restarts the parser after its own result

module string_table_stream_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire stsp_pkg::in_item_t  in_data_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  output stsp_pkg::out_item_t      out_data_o,
  input  wire logic                out_stall_i
);

  // input register
  logic               in_valid_q;
  stsp_pkg::in_item_t in_q;

  // result register
  logic                out_valid_q;
  stsp_pkg::out_item_t out_q;

  // parser state; an error parks the parser in the done phase until file_last
  stsp_pkg::phase_e phase_q, phase_d;
  logic [1:0]       biw_q, biw_d;
  logic [31:0]      acc_q, acc_d;
  logic [30:0]      labels_q, labels_d;
  logic [30:0]      pairs_q, pairs_d;
  logic [31:0]      bytes_q, bytes_d;
  logic             extra_q, extra_d;

  logic                adv;
  logic                fire;
  stsp_pkg::out_item_t res;
  logic                res_valid;
  logic [31:0]         w;
  logic [31:0]         bytes_dec;
  logic [30:0]         pairs_dec;
  logic [30:0]         labels_dec;
  logic                ev_after_name;
  logic                ev_close_pair;
  logic                ev_close_label;

  // the result register can take a new value
  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    phase_d        = phase_q;
    biw_d          = biw_q;
    acc_d          = acc_q;
    labels_d       = labels_q;
    pairs_d        = pairs_q;
    bytes_d        = bytes_q;
    extra_d        = extra_q;
    res            = '0;
    res_valid      = 1'b0;
    ev_after_name  = 1'b0;
    ev_close_pair  = 1'b0;
    ev_close_label = 1'b0;

    // word assembled so far including this byte
    w          = acc_q | ({24'd0, in_q.data_byte} << {biw_q, 3'b000});
    bytes_dec  = bytes_q - 32'd1;
    pairs_dec  = pairs_q - 31'd1;
    labels_dec = labels_q - 31'd1;

    if (phase_q inside {stsp_pkg::PH_NAME, stsp_pkg::PH_VALUE, stsp_pkg::PH_EXTRA}) begin
      // string body bytes
      bytes_d   = bytes_dec;
      res_valid = 1'b1;
      case (phase_q)
        stsp_pkg::PH_NAME: begin
          res.kind = stsp_pkg::KindLabelChar;
          // fold ascii upper case to lower case
          res.word = {24'd0, (in_q.data_byte inside {[8'h41:8'h5A]}) ?
                             (in_q.data_byte + 8'h20) : in_q.data_byte};
          if (bytes_dec == 32'd0) ev_after_name = 1'b1;
        end
        stsp_pkg::PH_VALUE: begin
          res.kind = stsp_pkg::KindValueByte;
          res.word = {24'd0, ~in_q.data_byte};
          if (bytes_dec == 32'd0) begin
            if (extra_q) begin
              res.ends_string = 1'b1;
              phase_d         = stsp_pkg::PH_EXLEN;
            end else begin
              ev_close_pair = 1'b1;
            end
          end
        end
        default: begin
          res.kind = stsp_pkg::KindExtraByte;
          res.word = {24'd0, in_q.data_byte};
          if (bytes_dec == 32'd0) ev_close_pair = 1'b1;
        end
      endcase
    end else if (phase_q != stsp_pkg::PH_DONE) begin
      // header words, little-endian
      acc_d = w;
      biw_d = biw_q + 2'd1;
      if (biw_q == 2'd3) begin
        acc_d = '0;
        case (phase_q)
          stsp_pkg::PH_MAGIC: begin
            if (w != stsp_pkg::MagicWord) begin
              res_valid = 1'b1;
              res.kind  = stsp_pkg::KindError;
              res.word  = stsp_pkg::ErrMagic;
              phase_d   = stsp_pkg::PH_DONE;
            end else begin
              phase_d = stsp_pkg::PH_VERSION;
            end
          end
          stsp_pkg::PH_VERSION: begin
            res_valid = 1'b1;
            res.kind  = stsp_pkg::KindVersion;
            res.word  = w;
            phase_d   = stsp_pkg::PH_COUNT;
          end
          stsp_pkg::PH_COUNT: begin
            res_valid = 1'b1;
            res.kind  = stsp_pkg::KindLabelCnt;
            res.word  = w;
            // negative count means no labels
            labels_d  = w[31] ? 31'd0 : w[30:0];
            phase_d   = stsp_pkg::PH_SKIP1;
          end
          stsp_pkg::PH_SKIP1: phase_d = stsp_pkg::PH_SKIP2;
          stsp_pkg::PH_SKIP2: phase_d = stsp_pkg::PH_LANG;
          stsp_pkg::PH_LANG: begin
            res_valid = 1'b1;
            res.kind  = stsp_pkg::KindLanguage;
            res.word  = w;
            if (labels_q == 31'd0) begin
              res.ends_file = 1'b1;
              phase_d       = stsp_pkg::PH_DONE;
            end else begin
              phase_d = stsp_pkg::PH_LTAG;
            end
          end
          stsp_pkg::PH_LTAG: begin
            if (w != stsp_pkg::LabelTag) begin
              res_valid = 1'b1;
              res.kind  = stsp_pkg::KindError;
              res.word  = stsp_pkg::ErrTag;
              phase_d   = stsp_pkg::PH_DONE;
            end else begin
              phase_d = stsp_pkg::PH_NPAIRS;
            end
          end
          stsp_pkg::PH_NPAIRS: begin
            if (w[31]) begin
              res_valid = 1'b1;
              res.kind  = stsp_pkg::KindError;
              res.word  = stsp_pkg::ErrLength;
              phase_d   = stsp_pkg::PH_DONE;
            end else begin
              pairs_d = w[30:0];
              phase_d = stsp_pkg::PH_NAMELEN;
            end
          end
          stsp_pkg::PH_NAMELEN: begin
            res_valid = 1'b1;
            if (w[31]) begin
              res.kind = stsp_pkg::KindError;
              res.word = stsp_pkg::ErrLength;
              phase_d  = stsp_pkg::PH_DONE;
            end else begin
              res.kind       = stsp_pkg::KindLabelHdr;
              res.word       = {1'b0, pairs_q};
              res.str_length = w[30:0];
              bytes_d        = w;
              if (w == 32'd0) ev_after_name = 1'b1;
              else            phase_d = stsp_pkg::PH_NAME;
            end
          end
          stsp_pkg::PH_PTAG: begin
            // tag parked in the byte counter until the length arrives
            extra_d = (w == stsp_pkg::WrtsTag);
            bytes_d = w;
            phase_d = stsp_pkg::PH_VALLEN;
          end
          stsp_pkg::PH_VALLEN: begin
            res_valid = 1'b1;
            if (w[31]) begin
              res.kind = stsp_pkg::KindError;
              res.word = stsp_pkg::ErrLength;
              phase_d  = stsp_pkg::PH_DONE;
            end else begin
              res.kind       = stsp_pkg::KindPairHdr;
              res.word       = bytes_q;
              res.str_length = w[30:0];
              res.has_extra  = extra_q;
              // utf-16 units to bytes
              bytes_d        = {w[30:0], 1'b0};
              if (w == 32'd0) begin
                if (extra_q) begin
                  res.ends_string = 1'b1;
                  phase_d         = stsp_pkg::PH_EXLEN;
                end else begin
                  ev_close_pair = 1'b1;
                end
              end else begin
                phase_d = stsp_pkg::PH_VALUE;
              end
            end
          end
          stsp_pkg::PH_EXLEN: begin
            res_valid = 1'b1;
            if (w[31]) begin
              res.kind = stsp_pkg::KindError;
              res.word = stsp_pkg::ErrLength;
              phase_d  = stsp_pkg::PH_DONE;
            end else begin
              res.kind       = stsp_pkg::KindExtraHdr;
              res.str_length = w[30:0];
              bytes_d        = w;
              if (w == 32'd0) ev_close_pair = 1'b1;
              else            phase_d = stsp_pkg::PH_EXTRA;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end

    // closing of strings, pairs and labels
    if (ev_close_pair) begin
      res.ends_string = 1'b1;
      res.ends_pair   = 1'b1;
      pairs_d         = pairs_dec;
      if (pairs_dec == 31'd0) ev_close_label = 1'b1;
      else                    phase_d = stsp_pkg::PH_PTAG;
    end
    if (ev_after_name) begin
      res.ends_string = 1'b1;
      if (pairs_q == 31'd0) ev_close_label = 1'b1;
      else                  phase_d = stsp_pkg::PH_PTAG;
    end
    if (ev_close_label) begin
      res.ends_label = 1'b1;
      labels_d       = labels_dec;
      if (labels_dec == 31'd0) begin
        res.ends_file = 1'b1;
        phase_d       = stsp_pkg::PH_DONE;
      end else begin
        phase_d = stsp_pkg::PH_LTAG;
      end
    end

    // end of file: truncation error unless finished or failed, then restart
    if (in_q.file_last) begin
      if (phase_d != stsp_pkg::PH_DONE) begin
        res       = '0;
        res_valid = 1'b1;
        res.kind  = stsp_pkg::KindError;
        res.word  = stsp_pkg::ErrTruncated;
      end
      phase_d  = stsp_pkg::PH_MAGIC;
      biw_d    = '0;
      acc_d    = '0;
      labels_d = '0;
      pairs_d  = '0;
      bytes_d  = '0;
      extra_d  = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= stsp_pkg::PH_MAGIC;
      biw_q    <= '0;
      acc_q    <= '0;
      labels_q <= '0;
      pairs_q  <= '0;
      bytes_q  <= '0;
      extra_q  <= 1'b0;
    end else if (fire) begin
      phase_q  <= phase_d;
      biw_q    <= biw_d;
      acc_q    <= acc_d;
      labels_q <= labels_d;
      pairs_q  <= pairs_d;
      bytes_q  <= bytes_d;
      extra_q  <= extra_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  // a closed pair always closes its string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.ends_pair |-> out_q.ends_string)
    else $error("pair closed without closing its string");

  // the file ends only on a label close or on the language word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.ends_file |->
      (out_q.ends_label || out_q.kind == stsp_pkg::KindLanguage))
    else $error("file end on unexpected result");

  // no word is half assembled while inside a string or after the end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == stsp_pkg::PH_NAME || phase_q == stsp_pkg::PH_VALUE ||
     phase_q == stsp_pkg::PH_EXTRA || phase_q == stsp_pkg::PH_DONE) |-> biw_q == 2'd0)
    else $error("byte position not aligned in a string phase");

  // input is only held back by a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled without a stalled result");

  // error results carry no length and no close flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == stsp_pkg::KindError |->
      out_q.str_length == '0 && !out_q.ends_string && !out_q.ends_file)
    else $error("error result with stray fields");

endmodule

`default_nettype wire

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stsp_pkg::*;

  // defects that a generated file can carry
  localparam int FaultNone     = 0;
  localparam int FaultMagic    = 1;
  localparam int FaultTag      = 2;
  localparam int FaultNegCount = 3;

  // where a negative length word is planted
  localparam int SpotNone  = -1;
  localparam int SpotPairs = 0;
  localparam int SpotName  = 1;
  localparam int SpotValue = 2;
  localparam int SpotExtra = 3;

  // how a generated file is closed off
  localparam int EndExact = 0;
  localparam int EndCut   = 1;
  localparam int EndTrail = 2;

  localparam logic [31:0] PlainTag     = 32'h5354_5220;
  localparam logic [31:0] AsciiBorders = 32'h7B60_5B40;  // bytes next to the upper-case and lower-case ranges

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;
  logic      out_stall_i = 1'b0;

  string_table_stream_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  always #4 clk_i = ~clk_i;

  // file bytes waiting to be sent, results the parser owes us
  in_item_t    file_stream[$];
  out_item_t   parse_results_due[$];
  logic [7:0]  file_bytes[$];
  int          bad_len_spot = SpotNone;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  // ---------------------------------------------------------------------------
  // parser state as the predictor sees it
  // ---------------------------------------------------------------------------
  phase_e      parse_phase = PH_MAGIC;
  logic [1:0]  byte_pos    = '0;
  logic [31:0] word_acc    = '0;
  logic [30:0] labels_left = '0;
  logic [30:0] pairs_left  = '0;
  logic [31:0] bytes_left  = '0;
  logic        wrts_pair   = 1'b0;
  logic        stopped     = 1'b0;

  function automatic void restart_parser();
    parse_phase = PH_MAGIC;
    byte_pos    = '0;
    word_acc    = '0;
    labels_left = '0;
    pairs_left  = '0;
    bytes_left  = '0;
    wrts_pair   = 1'b0;
    stopped     = 1'b0;
  endfunction

  function automatic out_item_t result_of(logic [3:0] k, logic [31:0] wd, logic [30:0] len,
                                          logic ex);
    out_item_t r;
    r            = '0;
    r.kind       = k;
    r.word       = wd;
    r.str_length = len;
    r.has_extra  = ex;
    return r;
  endfunction

  function automatic bit halt_with(logic [31:0] code, output out_item_t r);
    r       = result_of(KindError, code, '0, 1'b0);
    stopped = 1'b1;
    return 1'b1;
  endfunction

  function automatic void close_label(inout out_item_t r);
    r.ends_label = 1'b1;
    labels_left  = labels_left - 31'd1;
    if (labels_left == '0) begin
      r.ends_file = 1'b1;
      parse_phase = PH_DONE;
    end else begin
      parse_phase = PH_LTAG;
    end
  endfunction

  function automatic void end_of_name(inout out_item_t r);
    r.ends_string = 1'b1;
    if (pairs_left == '0) close_label(r);
    else parse_phase = PH_PTAG;
  endfunction

  function automatic void close_pair(inout out_item_t r);
    r.ends_string = 1'b1;
    r.ends_pair   = 1'b1;
    pairs_left    = pairs_left - 31'd1;
    if (pairs_left == '0) close_label(r);
    else parse_phase = PH_PTAG;
  endfunction

  // a WRTS value still owes its extra string, anything else closes the pair
  function automatic void end_of_value(inout out_item_t r);
    if (wrts_pair) begin
      r.ends_string = 1'b1;
      parse_phase   = PH_EXLEN;
    end else begin
      close_pair(r);
    end
  endfunction

  function automatic bit step_byte(logic [7:0] b, inout out_item_t r);
    logic [31:0] w;
    logic [7:0]  lc;
    if (parse_phase == PH_NAME || parse_phase == PH_VALUE || parse_phase == PH_EXTRA) begin
      bytes_left = bytes_left - 32'd1;
      if (parse_phase == PH_NAME) begin
        lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
        r  = result_of(KindLabelChar, {24'd0, lc}, '0, 1'b0);
        if (bytes_left == '0) end_of_name(r);
      end else if (parse_phase == PH_VALUE) begin
        r = result_of(KindValueByte, {24'd0, ~b}, '0, 1'b0);
        if (bytes_left == '0) end_of_value(r);
      end else begin
        r = result_of(KindExtraByte, {24'd0, b}, '0, 1'b0);
        if (bytes_left == '0) close_pair(r);
      end
      return 1'b1;
    end
    // header words arrive little-endian
    word_acc = word_acc | ({24'd0, b} << (8 * byte_pos));
    byte_pos = byte_pos + 2'd1;
    if (byte_pos != '0) return 1'b0;
    w        = word_acc;
    word_acc = '0;
    case (parse_phase)
      PH_MAGIC: begin
        if (w != MagicWord) return halt_with(ErrMagic, r);
        parse_phase = PH_VERSION;
        return 1'b0;
      end
      PH_VERSION: begin
        r           = result_of(KindVersion, w, '0, 1'b0);
        parse_phase = PH_COUNT;
        return 1'b1;
      end
      PH_COUNT: begin
        r           = result_of(KindLabelCnt, w, '0, 1'b0);
        labels_left = w[31] ? '0 : w[30:0];  // negative count means an empty table
        parse_phase = PH_SKIP1;
        return 1'b1;
      end
      PH_SKIP1: begin
        parse_phase = PH_SKIP2;
        return 1'b0;
      end
      PH_SKIP2: begin
        parse_phase = PH_LANG;
        return 1'b0;
      end
      PH_LANG: begin
        r = result_of(KindLanguage, w, '0, 1'b0);
        if (labels_left == '0) begin
          r.ends_file = 1'b1;
          parse_phase = PH_DONE;
        end else begin
          parse_phase = PH_LTAG;
        end
        return 1'b1;
      end
      PH_LTAG: begin
        if (w != LabelTag) return halt_with(ErrTag, r);
        parse_phase = PH_NPAIRS;
        return 1'b0;
      end
      PH_NPAIRS: begin
        if (w[31]) return halt_with(ErrLength, r);
        pairs_left  = w[30:0];
        parse_phase = PH_NAMELEN;
        return 1'b0;
      end
      PH_NAMELEN: begin
        if (w[31]) return halt_with(ErrLength, r);
        r          = result_of(KindLabelHdr, {1'b0, pairs_left}, w[30:0], 1'b0);
        bytes_left = w;
        if (w == '0) end_of_name(r);
        else parse_phase = PH_NAME;
        return 1'b1;
      end
      PH_PTAG: begin
        // the tag waits in the byte counter until its length word arrives
        wrts_pair   = (w == WrtsTag);
        bytes_left  = w;
        parse_phase = PH_VALLEN;
        return 1'b0;
      end
      PH_VALLEN: begin
        if (w[31]) return halt_with(ErrLength, r);
        r          = result_of(KindPairHdr, bytes_left, w[30:0], wrts_pair);
        bytes_left = w << 1;  // utf-16 units to bytes
        if (w == '0) end_of_value(r);
        else parse_phase = PH_VALUE;
        return 1'b1;
      end
      PH_EXLEN: begin
        if (w[31]) return halt_with(ErrLength, r);
        r          = result_of(KindExtraHdr, '0, w[30:0], 1'b0);
        bytes_left = w;
        if (w == '0) close_pair(r);
        else parse_phase = PH_EXTRA;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // one accepted byte; a last byte that leaves the parse open turns into a truncation error
  function automatic bit parse_byte(in_item_t it, output out_item_t r);
    bit got;
    r   = '0;
    got = 1'b0;
    if (!stopped && parse_phase != PH_DONE) got = step_byte(it.data_byte, r);
    if (it.file_last) begin
      if (!stopped && parse_phase != PH_DONE) begin
        r   = result_of(KindError, ErrTruncated, '0, 1'b0);
        got = 1'b1;
      end
      restart_parser();
    end
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // file generation
  // ---------------------------------------------------------------------------
  function automatic void put_word(logic [31:0] w);
    for (int k = 0; k < 4; k++) file_bytes.push_back(w[8*k +: 8]);
  endfunction

  // length word, or a negative one where the planted fault sits
  function automatic logic [31:0] length_word(int spot, int n);
    if (spot == bad_len_spot) begin
      bad_len_spot = SpotNone;
      return $urandom() | 32'h8000_0000;
    end
    return 32'(n);
  endfunction

  function automatic void make_file(int fault, int nlab);
    int          npairs;
    int          nlen;
    int          vlen;
    int          xlen;
    logic [31:0] tag;
    if (bad_len_spot != SpotNone && nlab == 0) nlab = 1;
    file_bytes.delete();
    put_word(fault == FaultMagic ? MagicWord ^ (32'd1 << $urandom_range(31)) : MagicWord);
    put_word($urandom());
    put_word(fault == FaultNegCount ? ($urandom() | 32'h8000_0000) : 32'(nlab));
    repeat (3) put_word($urandom());
    for (int l = 0; l < nlab; l++) begin
      put_word((fault == FaultTag && l == nlab - 1) ? LabelTag ^ (32'd1 << $urandom_range(31))
                                                     : LabelTag);
      npairs = $urandom_range(0, 3);
      if (bad_len_spot >= SpotValue && npairs == 0) npairs = 1;
      put_word(length_word(SpotPairs, npairs));
      nlen = $urandom_range(0, 6);
      put_word(length_word(SpotName, nlen));
      repeat (nlen) begin
        case ($urandom_range(3))
          0, 1: file_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
          2:    file_bytes.push_back(AsciiBorders[8*$urandom_range(3) +: 8]);
          default: file_bytes.push_back(8'($urandom()));
        endcase
      end
      for (int q = 0; q < npairs; q++) begin
        case ($urandom_range(3))
          0, 1: tag = WrtsTag;
          2:    tag = PlainTag;
          default: tag = $urandom_range(1) ? $urandom() : WrtsTag ^ (32'd1 << $urandom_range(31));
        endcase
        if (bad_len_spot == SpotExtra) tag = WrtsTag;
        put_word(tag);
        vlen = $urandom_range(0, 3);
        put_word(length_word(SpotValue, vlen));
        repeat (2 * vlen) file_bytes.push_back(8'($urandom()));
        if (tag == WrtsTag) begin
          xlen = $urandom_range(0, 4);
          put_word(length_word(SpotExtra, xlen));
          repeat (xlen) file_bytes.push_back(8'($urandom()));
        end
      end
    end
  endfunction

  // huge counts and lengths; the file almost always ends long before they run out
  function automatic void make_wild_file();
    file_bytes.delete();
    put_word(MagicWord);
    put_word($urandom());
    put_word(($urandom() & 32'h7FFF_FFFF) | 32'd1);
    repeat (3) put_word($urandom());
    put_word(LabelTag);
    put_word($urandom() & 32'h7FFF_FFFF);
    if ($urandom_range(1)) begin
      put_word($urandom() & 32'h7FFF_FFFF);
    end else begin
      put_word(32'd2);
      repeat (2) file_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
    end
    put_word(WrtsTag);
    put_word($urandom() & 32'h7FFF_FFFF);
    repeat (3) file_bytes.push_back(8'($urandom()));
  endfunction

  function automatic void queue_file(int ending);
    in_item_t    it;
    int unsigned cut;
    if (ending == EndCut) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end else if (ending == EndTrail) begin
      repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom()));
    end
    foreach (file_bytes[i]) begin
      it.data_byte = file_bytes[i];
      it.file_last = (i == file_bytes.size() - 1);
      file_stream.push_back(it);
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] due);
    $display("%0t: %s: got %h, expected %h", $time, what, seen, due);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: one file byte per transaction, held while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (file_stream.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= file_stream.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on every accepted byte, then check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t predicted;
    out_item_t due;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (parse_byte(in_data_i, predicted)) parse_results_due.push_back(predicted);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (parse_results_due.size() == 0) begin
        report_mismatch("result with none due, kind", {28'd0, out_data_o.kind}, '0);
      end else begin
        due = parse_results_due.pop_front();
        if (out_data_o.kind !== due.kind)
          report_mismatch("kind", {28'd0, out_data_o.kind}, {28'd0, due.kind});
        if (out_data_o.word !== due.word)
          report_mismatch("word", out_data_o.word, due.word);
        if (out_data_o.str_length !== due.str_length)
          report_mismatch("str_length", {1'b0, out_data_o.str_length}, {1'b0, due.str_length});
        if (out_data_o.has_extra !== due.has_extra)
          report_mismatch("has_extra", {31'd0, out_data_o.has_extra}, {31'd0, due.has_extra});
        if (out_data_o.ends_string !== due.ends_string)
          report_mismatch("ends_string", {31'd0, out_data_o.ends_string}, {31'd0, due.ends_string});
        if (out_data_o.ends_pair !== due.ends_pair)
          report_mismatch("ends_pair", {31'd0, out_data_o.ends_pair}, {31'd0, due.ends_pair});
        if (out_data_o.ends_label !== due.ends_label)
          report_mismatch("ends_label", {31'd0, out_data_o.ends_label}, {31'd0, due.ends_label});
        if (out_data_o.ends_file !== due.ends_file)
          report_mismatch("ends_file", {31'd0, out_data_o.ends_file}, {31'd0, due.ends_file});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed files first, then random files across four idling phases
  // ---------------------------------------------------------------------------
  int unsigned sender_idle_by_phase[4] = '{0, 88, 0, 30};
  int unsigned recv_stall_by_phase[4]  = '{0, 0, 88, 30};

  initial begin
    int r;
    int fault;
    int nlab;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      @(negedge clk_i);
      sender_idle_pct = sender_idle_by_phase[p];
      recv_stall_pct  = recv_stall_by_phase[p];
      if (p == 0) begin
        // a lone last byte
        file_bytes.delete();
        file_bytes.push_back(8'h20);
        queue_file(EndExact);
        make_file(FaultMagic, 1);
        queue_file(EndExact);
        // negative label count, labels that follow are ignored
        make_file(FaultNegCount, 1);
        queue_file(EndExact);
        // empty table with bytes after completion
        make_file(FaultNone, 0);
        queue_file(EndTrail);
        make_file(FaultNone, 3);
        queue_file(EndExact);
        make_file(FaultTag, 2);
        queue_file(EndExact);
        for (int s = SpotPairs; s <= SpotExtra; s++) begin
          bad_len_spot = s;
          make_file(FaultNone, 1);
          queue_file(EndExact);
        end
        bad_len_spot = SpotNone;
        make_wild_file();
        queue_file(EndExact);
        make_file(FaultNone, 2);
        queue_file(EndCut);
      end
      while (file_stream.size() < 475) begin
        r = $urandom_range(99);
        bad_len_spot = SpotNone;
        if (r < 12) begin
          make_wild_file();
          queue_file(EndExact);
        end else begin
          fault = (r < 20) ? FaultMagic : (r < 28) ? FaultTag :
                  (r < 35) ? FaultNegCount : FaultNone;
          if (r >= 35 && r < 45) bad_len_spot = $urandom_range(SpotPairs, SpotExtra);
          nlab = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
          make_file(fault, nlab);
          r = $urandom_range(99);
          queue_file(r < 70 ? EndExact : r < 85 ? EndCut : EndTrail);
        end
      end
      // wait until every byte is sent and every owed result has come back
      while (file_stream.size() != 0 || in_valid_i || parse_results_due.size() != 0)
        @(negedge clk_i);
    end
    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
rtl/core/stsp_pkg.sv
rtl/core/string_table_stream_parser.sv
tb/tb.sv
